// ===== src/pdws_pkg.sv =====
//==============================================================================
// pdws_pkg: shared types and constants for the PWM divider and wrap solver.
// Holds the fixed widths and clamp limits and the result word type.
//==============================================================================
`default_nettype none
package pdws_pkg;
    localparam int unsigned FREQ_W = 20;
    localparam int unsigned WRAP_W = 16;
    localparam int unsigned WHOLE_W = 8;
    localparam int unsigned SIXT_W = 4;
    localparam logic [WHOLE_W-1:0] WHOLE_MAX = 8'd255;
    localparam logic [16:0] PERIOD_MAX = 17'd65536;
    localparam logic [16:0] PERIOD_MIN = 17'd2;
    localparam logic [4:0] FRAC_STEPS = 5'd16;

    // One result word.
    typedef struct packed {
        logic [WRAP_W-1:0] wrap_value;
        logic [WHOLE_W-1:0] divider_whole;
        logic [SIXT_W-1:0] divider_sixteenths;
        logic freq_invalid;
    } t_result;
endpackage
`default_nettype wire

// ===== src/pdws_if.sv =====
//==============================================================================
// pdws_if: valid/ready channel that carries one word of type T.
// The source drives valid and data; the sink drives ready.
//==============================================================================
`default_nettype none
interface pdws_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/pdws_divider.sv =====
//==============================================================================
// pdws_divider: pipelined restoring divider, one quotient bit per stage.
// Carries a side-band word alongside each division; stalls hold every stage.
//==============================================================================
`default_nettype none
module pdws_divider #(
    parameter int unsigned NUM_W = 40,
    parameter int unsigned DEN_W = 40,
    parameter int unsigned QUO_W = 18,
    parameter int unsigned SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [QUO_W-1:0]       o_quo,
    output logic [SIDE_W-1:0]      o_side
);
    // Partial remainder is wide enough for the numerator.
    localparam int unsigned REM_W = NUM_W + 1;
    // Trial divisor holds the divisor at its largest shift without losing bits.
    localparam int unsigned TR_W = (REM_W > DEN_W + QUO_W) ? REM_W : DEN_W + QUO_W;

    logic [QUO_W:0]             r_vld;
    logic [REM_W-1:0]           r_rem [QUO_W+1];
    logic [DEN_W-1:0]           r_den [QUO_W+1];
    logic [QUO_W-1:0]           r_quo [QUO_W+1];
    logic [SIDE_W-1:0]          r_side [QUO_W+1];

    // Stage 0 loads the operands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QUO_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= REM_W'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    // Each stage decides one quotient bit, most significant first.
    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        localparam int unsigned SH = QUO_W - 1 - g;
        logic [TR_W-1:0] w_trial;
        logic            w_fit;
        assign w_trial = TR_W'(r_den[g]) << SH;
        assign w_fit = TR_W'(r_rem[g]) >= w_trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= w_fit ? REM_W'(TR_W'(r_rem[g]) - w_trial)
                                    : r_rem[g];
                r_quo[g+1] <= r_quo[g] | (QUO_W'(w_fit) << SH);
                r_den[g+1] <= r_den[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_valid = r_vld[QUO_W];
    assign o_quo = r_quo[QUO_W];
    assign o_side = r_side[QUO_W];
endmodule
`default_nettype wire

// ===== src/pwm_divider_wrap_solver_core.sv =====
//==============================================================================
// pwm_divider_wrap_solver_core: PWM wrap and 8.4 clock divider for a tone.
// Three chained pipelined dividers give whole, period and rounded fraction.
//==============================================================================
// One word enters per cycle while the output word is taken. The pipeline has
// QA_W + Q2_W + Q3_W + 8 register stages, 50 with the default clock and
// table length, set by the three bit-per-stage dividers (whole part, period,
// rounded sixteenths). The whole pipeline holds when the output word is not
// taken; otherwise throughput is one word per cycle.
// A zero frequency gives freq_invalid = 1 and zeros in the other fields.
`default_nettype none
module pwm_divider_wrap_solver_core #(
    parameter int unsigned CLOCK_HZ = 125000000,
    parameter int unsigned TABLE_LEN = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pdws_if.sink      i_in,
    pdws_if.source    o_out
);
    localparam int unsigned LEN_W = $clog2(TABLE_LEN + 1);
    localparam int unsigned DEN_W = pdws_pkg::FREQ_W + LEN_W;     // f*N
    localparam int unsigned CLK_W = $clog2(CLOCK_HZ + 1);
    // 32*clk + den*period, where den*period is at most clk or 2*den.
    localparam int unsigned NUM_W = (CLK_W + 6 > DEN_W + 2) ? CLK_W + 6 : DEN_W + 2;
    localparam int unsigned D1_W = DEN_W + 16;
    localparam int unsigned D2_W = DEN_W + 8;
    localparam int unsigned D3_W = DEN_W + 18;
    localparam int unsigned QA_W = (CLK_W > 16) ? CLK_W - 16 + 1 : 1;
    // The raw period exceeds 17 bits only when the whole part is clamped.
    localparam int unsigned Q2_RAW = $clog2(CLOCK_HZ / (TABLE_LEN * 255) + 1);
    localparam int unsigned Q2_W = (Q2_RAW > 17) ? Q2_RAW : 17;
    // The rounded fraction grows past 13 bits only when the period is clamped.
    localparam int unsigned Q3_RAW = $clog2(CLOCK_HZ / (TABLE_LEN * 4096) + 2);
    localparam int unsigned Q3_W = (Q3_RAW > 13) ? Q3_RAW : 13;
    localparam logic [NUM_W-1:0] CLK_N = NUM_W'(CLOCK_HZ);

    logic w_en;
    assign w_en = o_out.ready || !o_out.valid;
    assign i_in.ready = w_en;

    // Stage A: den = f * N, registered.
    logic r_av;
    logic [DEN_W-1:0] r_den;
    logic r_zero;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_av <= 1'b0;
        else if (w_en) r_av <= i_in.valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_den <= DEN_W'(i_in.data) * DEN_W'(TABLE_LEN);
            r_zero <= i_in.data == '0;
        end
    end

    // Divider 1: clk / (den * 65536).
    logic v1;
    logic [QA_W-1:0] q1;
    logic [DEN_W:0] s1;
    pdws_divider #(.NUM_W(NUM_W), .DEN_W(D1_W), .QUO_W(QA_W), .SIDE_W(DEN_W+1)) u_div1 (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r_av),
        .i_num(CLK_N), .i_den({r_den, 16'd0}), .i_side({r_zero, r_den}),
        .o_valid(v1), .o_quo(q1), .o_side(s1)
    );

    // Stage B: clamp whole and form den*whole.
    logic r_bv;
    logic [pdws_pkg::WHOLE_W-1:0] r_whole;
    logic [DEN_W:0] r_sb;
    logic [D2_W-1:0] r_dw;
    logic [QA_W:0] w_w1;
    logic [pdws_pkg::WHOLE_W-1:0] w_wc;
    assign w_w1 = (QA_W+1)'(q1) + 1'b1;
    assign w_wc = (w_w1 > (QA_W+1)'(255)) ? pdws_pkg::WHOLE_MAX : pdws_pkg::WHOLE_W'(w_w1);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bv <= 1'b0;
        else if (w_en) r_bv <= v1;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_whole <= w_wc;
            r_sb <= s1;
            r_dw <= D2_W'(s1[DEN_W-1:0]) * D2_W'(w_wc);
        end
    end

    // Divider 2: clk / (den * whole), clamped to 17 bits in stage C.
    logic v2;
    logic [Q2_W-1:0] q2;
    logic [DEN_W+8:0] s2;
    pdws_divider #(.NUM_W(NUM_W), .DEN_W(D2_W), .QUO_W(Q2_W), .SIDE_W(DEN_W+9)) u_div2 (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r_bv),
        .i_num(CLK_N), .i_den(r_dw), .i_side({r_whole, r_sb}),
        .o_valid(v2), .o_quo(q2), .o_side(s2)
    );

    // Stage C: clamp period, form den*period.
    logic [16:0] w_p;
    logic w_big;
    assign w_big = (CLK_W > 17 + DEN_W) ? 1'b0 : 1'b0;
    assign w_p = (q2 > pdws_pkg::PERIOD_MAX) ? pdws_pkg::PERIOD_MAX :
                 (q2 < pdws_pkg::PERIOD_MIN) ? pdws_pkg::PERIOD_MIN : 17'(q2);
    logic r_cv;
    logic [16:0] r_per;
    logic [DEN_W+8:0] r_sc;
    logic [D3_W-1:0] r_dp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv <= 1'b0;
        else if (w_en) r_cv <= v2;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_per <= w_p | 17'(w_big);
            r_sc <= s2;
            r_dp <= D3_W'(s2[DEN_W-1:0]) * D3_W'(w_p);
        end
    end

    // Stage D: rounding numerator and doubled denominator.
    logic r_dv;
    logic [NUM_W-1:0] r_n3;
    logic [D3_W:0] r_d3;
    logic [16+DEN_W+8:0] r_sd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv <= 1'b0;
        else if (w_en) r_dv <= r_cv;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n3 <= (CLK_N << 5) + NUM_W'(r_dp);
            r_d3 <= {r_dp, 1'b0};
            r_sd <= {r_per[15:0], r_sc};
        end
    end

    // Divider 3: rounded 16*T/period.
    logic v3;
    logic [Q3_W-1:0] q3;
    logic [16+DEN_W+8:0] s3;
    pdws_divider #(.NUM_W(NUM_W), .DEN_W(D3_W+1), .QUO_W(Q3_W), .SIDE_W(16+DEN_W+9)) u_div3 (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r_dv),
        .i_num(r_n3), .i_den(r_d3), .i_side(r_sd),
        .o_valid(v3), .o_quo(q3), .o_side(s3)
    );

    // Output stage: fraction clamp and carry into whole.
    logic [pdws_pkg::WHOLE_W-1:0] w_wh;
    logic w_zf;
    logic [Q3_W-1:0] w_base;
    logic [Q3_W-1:0] w_sx;
    pdws_pkg::t_result w_res;
    pdws_pkg::t_result r_res;
    logic r_ov;
    assign w_wh = s3[DEN_W+8:DEN_W+1];
    assign w_zf = s3[DEN_W];
    assign w_base = Q3_W'(w_wh) << 4;
    assign w_sx = q3 - w_base;
    always_comb begin
        w_res.wrap_value = s3[16+DEN_W+8:DEN_W+9] - 16'd1;
        w_res.divider_whole = w_wh;
        w_res.divider_sixteenths = w_sx[3:0];
        w_res.freq_invalid = 1'b0;
        if (q3 < w_base) begin
            w_res.divider_sixteenths = '0;
        end else if (w_sx > Q3_W'(15)) begin
            w_res.divider_sixteenths = '0;
            if (w_wh != pdws_pkg::WHOLE_MAX) w_res.divider_whole = w_wh + 8'd1;
        end
        if (w_zf) begin
            w_res = '0;
            w_res.freq_invalid = 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= v3;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_res <= w_res;
    end
    assign o_out.valid = r_ov;
    assign o_out.data = r_res;
endmodule
`default_nettype wire
